/* rtl/sha_pkg.sv */
package sha_pkg;
  localparam int LENGTH_COUNTER_BITS = 61;
  localparam int LEN_W = LENGTH_COUNTER_BITS;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic       load_byte;
    logic [7:0] byte_val;
    logic       pad_start;
    logic       zero_fill;
    logic       put_len;
    logic       start_block;
    logic       round_step;
    logic       fold;
    logic       reinit;
    logic       clr_len;
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       last_round;
  } sha_stat_t;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction
endpackage

/* rtl/sha_if.sv */
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* rtl/sha_datapath.sv */
module sha_datapath
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sha_cmd_t    cmd,
  input  logic [2:0]  rd_idx,
  output sha_stat_t   stat,
  output logic [31:0] h_word
);
  // Block bytes shift in at the low end; during rounds the same register
  // is the 16-word schedule window, W[t] in the top word.
  logic [511:0]     blk;
  logic [31:0]      h [8];
  logic [31:0]      v [8];
  logic [5:0]       rnd;
  logic [5:0]       pos;
  logic [LEN_W-1:0] len;
  logic [63:0]      bits;
  logic [7:0]       len_byte, sh_byte;
  logic             sh_en;
  logic [31:0]      w0, w1, w9, w14, s0w, s1w, wnew, s1, ch, t1, s0, mj;

  assign bits = {{(64-LEN_W){1'b0}}, len} << 3;
  assign len_byte = bits[{~pos[2:0], 3'b000} +: 8];
  assign sh_en = cmd.load_byte | cmd.pad_start | cmd.zero_fill | cmd.put_len;
  assign stat.fill = pos;
  assign stat.last_round = (rnd == 6'd63);
  assign h_word = h[rd_idx];

  always_comb begin
    if (cmd.load_byte) sh_byte = cmd.byte_val;
    else if (cmd.pad_start) sh_byte = PAD_BYTE;
    else if (cmd.put_len) sh_byte = len_byte;
    else sh_byte = 8'h00;
  end

  assign w0   = blk[511:480];
  assign w1   = blk[479:448];
  assign w9   = blk[223:192];
  assign w14  = blk[63:32];
  assign s0w  = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
  assign s1w  = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
  assign wnew = w0 + s0w + w9 + s1w;
  assign s1   = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
  assign ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1   = v[7] + s1 + ch + ROUND_K[rnd] + w0;
  assign s0   = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
  assign mj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);

  always_ff @(posedge clk) begin
    if (sh_en) blk <= {blk[503:0], sh_byte};
    else if (cmd.round_step) blk <= {blk[479:0], wnew};
    if (cmd.start_block) begin
      for (int i = 0; i < 8; i++) v[i] <= h[i];
    end else if (cmd.round_step) begin
      for (int i = 1; i < 8; i++) if (i != 4) v[i] <= v[i-1];
      v[4] <= v[3] + t1;
      v[0] <= t1 + s0 + mj;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      pos <= '0;
      rnd <= '0;
      for (int i = 0; i < 8; i++) h[i] <= INIT_H[i];
    end else begin
      if (cmd.load_byte) len <= len + 1'b1;
      else if (cmd.clr_len) len <= '0;
      if (sh_en) pos <= pos + 6'd1;
      if (cmd.start_block) rnd <= '0;
      else if (cmd.round_step) rnd <= rnd + 1'b1;
      if (cmd.fold) for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
      else if (cmd.reinit) for (int i = 0; i < 8; i++) h[i] <= INIT_H[i];
    end
  end
endmodule

/* rtl/sha_ctrl.sv */
module sha_ctrl
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch,
  input  sha_stat_t stat,
  output sha_cmd_t  cmd,
  output logic [2:0] rd_idx,
  input  logic [31:0] h_word
);
  localparam logic [2:0] S_IDLE = 3'd0, S_START = 3'd1, S_ROUND = 3'd2, S_FOLD = 3'd3,
                         S_PAD = 3'd4, S_EMIT = 3'd5, S_ZERO = 3'd6, S_LEN = 3'd7;
  logic [2:0] state, state_next;
  logic [2:0] ret, ret_next;
  logic [2:0] idx, idx_next;
  logic       acc;

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_EMIT);
  assign out_ch.digest_word = h_word;
  assign out_ch.word_index = idx;
  assign out_ch.last_word = (idx == 3'd7);
  assign rd_idx = idx;

  always_comb begin
    cmd = '0;
    cmd.byte_val = in_ch.data_byte;
    state_next = state;
    ret_next = ret;
    idx_next = idx;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          cmd.load_byte = in_ch.byte_present;
          if (in_ch.byte_present && stat.fill == 6'd63) begin
            state_next = S_START;
            ret_next = in_ch.end_of_message ? S_PAD : S_IDLE;
          end else if (in_ch.end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.pad_start = 1'b1;
        if (stat.fill == 6'd55) state_next = S_LEN;
        else if (stat.fill == 6'd63) begin
          state_next = S_START;
          ret_next = S_ZERO;
        end else state_next = S_ZERO;
      end
      S_ZERO: begin
        cmd.zero_fill = 1'b1;
        if (stat.fill == 6'd55) state_next = S_LEN;
        else if (stat.fill == 6'd63) begin
          state_next = S_START;
          ret_next = S_ZERO;
        end
      end
      S_LEN: begin
        cmd.put_len = 1'b1;
        if (stat.fill == 6'd63) begin
          state_next = S_START;
          ret_next = S_EMIT;
        end
      end
      S_START: begin
        cmd.start_block = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
        if (stat.last_round) state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        state_next = ret;
      end
      S_EMIT: begin
        if (out_ch.ready) begin
          idx_next = idx + 3'd1;
          if (idx == 3'd7) begin
            cmd.reinit = 1'b1;
            cmd.clr_len = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      idx <= '0;
    end else begin
      state <= state_next;
      ret <= ret_next;
      idx <= idx_next;
    end
  end
endmodule

/* rtl/sha256_stream_hash_core.sv */
// Streaming SHA-256. One byte per input transfer while collecting; a transfer
// that completes a 64-byte block holds the input while the block is hashed
// (load, the 64 rounds, then fold). end_of_message appends 0x80, zeros and the
// length one byte per cycle, then runs the final block; a fill of 56 or more
// takes a second pass of 64 padding bytes and a second block. Then eight
// digest words H0..H7 follow, one per transfer, and input reopens.
module sha256_stream_hash_core
  import sha_pkg::*;
(
  input logic       clk,
  input logic       rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);
  sha_cmd_t    cmd;
  sha_stat_t   stat;
  logic [2:0]  rd_idx;
  logic [31:0] h_word;

  sha_ctrl u_ctrl (
    .clk, .rst, .in_ch, .out_ch, .stat, .cmd, .rd_idx, .h_word
  );

  sha_datapath u_dp (
    .clk, .rst, .cmd, .rd_idx, .stat, .h_word
  );

  a_no_both: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("input and output both open");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && out_ch.last_word |=> in_ch.ready)
    else $error("not idle after digest");
  a_idx: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.word_index))
    else $error("index moved while stalled");
endmodule
